// ===== design/falling_edge_divider_timer_macros.svh =====
// Assertion macros shared by the timer's checker.
// No dependencies; included by bare file name.
`ifndef FALLING_EDGE_DIVIDER_TIMER_MACROS_SVH
`define FALLING_EDGE_DIVIDER_TIMER_MACROS_SVH

// Clocked assertion, switched off while reset is asserted.
`define FEDT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define FEDT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/fedt_pkg.sv =====
// Shared types and constants of the divider/timer block.
// No dependencies; used by the top level.
package fedt_pkg;

  // Tap select registers
  localparam int unsigned NumTaps = 4;
  localparam int unsigned TapW    = 4;
  localparam int unsigned DivW    = 16;

  typedef logic [$clog2(NumTaps)-1:0] cfg_idx_t;
  typedef logic [TapW-1:0]            tap_t;
  typedef tap_t [NumTaps-1:0]         tap_tbl_t;

  localparam tap_tbl_t TapReset = {4'd7, 4'd5, 4'd3, 4'd9};

  // Request opcodes
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2
  } op_e;

  // Register map
  typedef enum logic [1:0] {
    REG_DIV = 2'd0,
    REG_CNT = 2'd1,
    REG_MOD = 2'd2,
    REG_CTL = 2'd3
  } reg_e;

  localparam logic [DivW-1:0] DivStep = 16'd4;
  localparam logic [7:0]      CtlPad  = 8'hF8;
  localparam int unsigned     CtlEnBit = 2;

  typedef struct packed {
    logic [1:0] opcode;
    logic [1:0] reg_select;
    logic [7:0] write_data;
  } req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       timer_irq;
  } rsp_t;

endpackage

// ===== design/fedt_stream_if.sv =====
// Valid/ready channel carrying one payload of a given type.
// No dependencies; payload type is set at instantiation.
interface fedt_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== design/falling_edge_divider_timer.sv =====
// Four-register divider/timer: top level.
// Depends on fedt_pkg and fedt_stream_if.
//
// Usage:
//   req_i carries one request: a machine-cycle tick, a register read or a
//   register write (divider, counter, modulo, control). rsp_o returns
//   exactly one response per request: read data (0 for ticks and writes)
//   and timer_irq, set on the tick that reloads the counter from modulo.
//   cfg_* writes the four divider tap selects; write only while idle.
// Timing:
//   Timer state is updated in the cycle a request is accepted; the response
//   is registered in the output register, or in the skid entry while the
//   output register still holds a response. One request per cycle is sustained while responses are taken.
// Reset:
//   rst_ni clears divider, counter, modulo, control and the edge/reload
//   flags, loads the tap selects with 9, 3, 5, 7 and empties the output.
// Stall:
//   A two-entry output buffer lets one more request in while a response
//   waits; req_i.ready then drops until the consumer takes a response.
module falling_edge_divider_timer (
  input  logic               clk_i,
  input  logic               rst_ni,
  fedt_stream_if.sink        req_i,
  fedt_stream_if.source      rsp_o,
  input  logic               cfg_we_i,
  input  fedt_pkg::cfg_idx_t cfg_index_i,
  input  fedt_pkg::tap_t     cfg_data_i
);
  import fedt_pkg::*;

  // Watched divider bit, gated by the enable bit
  function automatic logic watched(input logic [DivW-1:0] div,
                                   input logic [2:0]      ctl,
                                   input tap_tbl_t        taps);
    return ctl[CtlEnBit] & div[taps[ctl[1:0]]];
  endfunction

  tap_tbl_t        tap_q;
  logic [DivW-1:0] div_q, div_d, div_tick;
  logic [7:0]      cnt_q, cnt_d, cnt_base, mod_q, mod_d;
  logic [2:0]      ctl_q, ctl_d;
  logic            last_q, last_d, pend_q, pend_d;
  logic            wb_old, wb_tick, wb_ctl, bump;
  rsp_t            rsp_new;
  rsp_t            out_q, skid_q;
  logic            out_vld_q, skid_vld_q;
  logic            req_fire, rsp_fire, out_free;
  req_t            req;

  assign req      = req_i.payload;
  assign req_fire = req_i.valid & req_i.ready;
  assign rsp_fire = out_vld_q & rsp_o.ready;
  assign out_free = rsp_fire | ~out_vld_q;

  assign div_tick = div_q + DivStep;
  assign wb_old   = watched(div_q, ctl_q, tap_q);
  assign wb_tick  = watched(div_tick, ctl_q, tap_q);
  assign wb_ctl   = watched(div_q, req.write_data[2:0], tap_q);

  // Next state and response for the incoming request
  always_comb begin
    div_d    = div_q;
    mod_d    = mod_q;
    ctl_d    = ctl_q;
    last_d   = last_q;
    pend_d   = pend_q;
    cnt_base = cnt_q;
    bump     = 1'b0;
    rsp_new  = '0;
    unique case (req.opcode)
      OP_TICK: begin
        if (pend_q) begin
          pend_d            = 1'b0;
          cnt_base          = mod_q;
          rsp_new.timer_irq = 1'b1;
        end
        div_d  = div_tick;
        bump   = last_q & ~wb_tick;
        last_d = wb_tick;
      end
      OP_READ: begin
        unique case (req.reg_select)
          REG_DIV: rsp_new.read_data = div_q[DivW-1 -: 8];
          REG_CNT: rsp_new.read_data = cnt_q;
          REG_MOD: rsp_new.read_data = mod_q;
          REG_CTL: rsp_new.read_data = CtlPad | {5'd0, ctl_q};
          default: rsp_new.read_data = '0;
        endcase
      end
      OP_WRITE: begin
        unique case (req.reg_select)
          REG_DIV: begin
            // clearing the divider drops the watched bit
            div_d  = '0;
            bump   = wb_old & last_q;
            last_d = 1'b0;
          end
          REG_CNT: begin
            pend_d   = 1'b0;
            cnt_base = req.write_data;
          end
          REG_MOD: mod_d = req.write_data;
          REG_CTL: begin
            ctl_d  = req.write_data[2:0];
            bump   = wb_old & ~wb_ctl & last_q;
            last_d = wb_ctl;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    // counter increment; wrap schedules a reload
    cnt_d = cnt_base + {7'd0, bump};
    if (bump && (cnt_base == 8'hFF)) begin
      pend_d = 1'b1;
    end
  end

  // Timer state and tap selects
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_q  <= TapReset;
      div_q  <= '0;
      cnt_q  <= '0;
      mod_q  <= '0;
      ctl_q  <= '0;
      last_q <= 1'b0;
      pend_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        tap_q[cfg_index_i] <= cfg_data_i;
      end
      if (req_fire) begin
        div_q  <= div_d;
        cnt_q  <= cnt_d;
        mod_q  <= mod_d;
        ctl_q  <= ctl_d;
        last_q <= last_d;
        pend_q <= pend_d;
      end
    end
  end

  // Output buffer valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q  <= skid_vld_q | req_fire;
      skid_vld_q <= 1'b0;
    end else if (req_fire) begin
      skid_vld_q <= 1'b1;
    end
  end

  // Output buffer payload
  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_vld_q ? skid_q : rsp_new;
    end else if (req_fire) begin
      skid_q <= rsp_new;
    end
  end

  assign req_i.ready   = ~skid_vld_q;
  assign rsp_o.valid   = out_vld_q;
  assign rsp_o.payload = out_q;

endmodule

// ===== design/fedt_checker.sv =====
// Port-level checker for the divider/timer, bound to the top level.
// Depends on falling_edge_divider_timer_macros.svh.
`include "falling_edge_divider_timer_macros.svh"

module fedt_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       req_valid_i,
  input logic       req_ready_i,
  input logic       rsp_valid_i,
  input logic       rsp_ready_i,
  input logic [7:0] rsp_read_data_i,
  input logic       rsp_timer_irq_i
);

  // Requests accepted whose responses are not yet taken
  logic [1:0] inflight_q;
  logic       req_fire, rsp_fire;

  assign req_fire = req_valid_i & req_ready_i;
  assign rsp_fire = rsp_valid_i & rsp_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_q + {1'b0, req_fire} - {1'b0, rsp_fire};
    end
  end

  `FEDT_ASSERT_ALWAYS(a_rst_empty, clk_i, !rst_ni |-> !rsp_valid_i, "response valid in reset")
  `FEDT_ASSERT(a_no_orphan, clk_i, rst_ni, rsp_valid_i |-> inflight_q != 2'd0, "response without request")
  `FEDT_ASSERT(a_buf_full, clk_i, rst_ni, inflight_q == 2'd2 |-> !req_ready_i && inflight_q != 2'd3, "buffer overrun")
  `FEDT_ASSERT(a_irq_tick, clk_i, rst_ni, rsp_valid_i && rsp_timer_irq_i |-> rsp_read_data_i == 8'd0, "irq with read data")
  `FEDT_ASSERT(a_rsp_hold, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_read_data_i) && $stable(rsp_timer_irq_i), "stalled response changed")

endmodule

bind falling_edge_divider_timer fedt_checker u_fedt_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .req_valid_i     (req_i.valid),
  .req_ready_i     (req_i.ready),
  .rsp_valid_i     (rsp_o.valid),
  .rsp_ready_i     (rsp_o.ready),
  .rsp_read_data_i (rsp_o.payload.read_data),
  .rsp_timer_irq_i (rsp_o.payload.timer_irq)
);
